@@ hdl/iirdf2_pkg.sv @@
// Shared types and constants for the direct form II IIR filter.
// Used by iirdf2_ctrl, iirdf2_datapath and iir_filter_direct_form_two_top.
package iirdf2_pkg;

    localparam int MAX_ORDER    = 8;
    localparam int SAMPLE_WIDTH = 16;
    localparam int STATE_WIDTH  = 24;
    localparam int COEF_WIDTH   = 16;
    localparam int FRAC_BITS    = COEF_WIDTH - 2;
    localparam int CNT_WIDTH    = 4;
    localparam int TAP_WIDTH    = $clog2(MAX_ORDER);
    localparam int REG_WIDTH    = 64;
    localparam int IDX_WIDTH    = 3;
    // 8 products of COEF x STATE bits plus growth, well inside this width
    localparam int ACC_WIDTH    = 48;
    localparam int SUM_WIDTH    = ACC_WIDTH - FRAC_BITS + 1;
    localparam int OUT_BYTES    = (STATE_WIDTH + 7) / 8;
    localparam int IN_BYTES     = (SAMPLE_WIDTH + 7) / 8;

    // configuration register indexes
    localparam logic [IDX_WIDTH-1:0] REG_FB_COUNT = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_FF_COUNT = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_FB_LOW   = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_FB_HIGH  = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_FF_LOW   = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_FF_HIGH  = 3'd5;

    typedef struct packed {
        logic                 start;      // load sample, clear the clip flag
        logic                 mac;        // add coefficient x data into the accumulator
        logic                 acc_clear;  // restart accumulation from zero
        logic                 use_w;      // multiply the new intermediate value w
        logic                 coef_ff;    // take the feedforward bank
        logic [TAP_WIDTH-1:0] coef_idx;
        logic [TAP_WIDTH-1:0] data_idx;
        logic                 load_w;     // form and saturate w
        logic                 finish;     // load output word, shift delay line unless err
        logic                 y_bypass;   // no feedforward taps: y = w
        logic                 err;        // both counts zero
    } iirdf2_cmd_t;

    typedef struct packed {
        logic [CNT_WIDTH-1:0] nf;        // clamped feedback count
        logic [CNT_WIDTH-1:0] nff;       // clamped feedforward count
        logic                 out_busy;  // output word held and not taken
    } iirdf2_status_t;

endpackage

@@ hdl/iirdf2_ctrl.sv @@
// Sequencer for the direct form II IIR filter: steps the shared MAC over the taps.
// Depends on iirdf2_pkg; drives iirdf2_datapath through iirdf2_cmd_t.
module iirdf2_ctrl
    import iirdf2_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  iirdf2_status_t status,
    output iirdf2_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FB     = 3'd1;
    localparam logic [2:0] S_WCALC  = 3'd2;
    localparam logic [2:0] S_FF     = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [CNT_WIDTH-1:0] k_reg, k_next;
    logic                 err_reg, err_next;
    logic [CNT_WIDTH-1:0] k_dec;
    logic                 s_accept;
    logic                 both_zero;

    assign k_dec     = k_reg - CNT_WIDTH'(1);
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign both_zero = (status.nf == '0) && (status.nff == '0);

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        err_next     = err_reg;
        cmd          = '0;
        cmd.coef_idx = k_reg[TAP_WIDTH-1:0];
        cmd.data_idx = k_reg[TAP_WIDTH-1:0];
        cmd.y_bypass = (status.nff == '0);
        cmd.err      = err_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    cmd.start = 1'b1;
                    cmd.acc_clear = 1'b1;
                    k_next = '0;
                    err_next = both_zero;
                    if (both_zero)
                        state_next = S_FINISH;
                    else if (status.nf == '0)
                        state_next = S_WCALC;
                    else
                        state_next = S_FB;
                end
            end
            S_FB:
            begin
                cmd.mac = 1'b1;
                if (k_reg == status.nf - CNT_WIDTH'(1))
                begin
                    k_next = '0;
                    state_next = S_WCALC;
                end
                else
                    k_next = k_reg + CNT_WIDTH'(1);
            end
            S_WCALC:
            begin
                cmd.load_w = 1'b1;
                state_next = (status.nff == '0) ? S_FINISH : S_FF;
            end
            S_FF:
            begin
                cmd.mac       = 1'b1;
                cmd.coef_ff   = 1'b1;
                cmd.use_w     = (k_reg == '0);
                cmd.acc_clear = (k_reg == '0);
                cmd.data_idx  = k_dec[TAP_WIDTH-1:0];
                if (k_reg == status.nff - CNT_WIDTH'(1))
                    state_next = S_FINISH;
                else
                    k_next = k_reg + CNT_WIDTH'(1);
            end
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            err_reg   <= err_next;
        end
    end

    a_fb_needs_taps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FB |-> status.nf != '0)
        else $error("feedback loop entered with no feedback taps");

    a_finish_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !status.out_busy)
        else $error("output word overwritten before it was taken");

    a_err_skips_mac: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && both_zero |=> state_reg == S_FINISH && err_reg)
        else $error("config error did not go straight to finish");

endmodule

@@ hdl/iirdf2_datapath.sv @@
// Datapath of the direct form II IIR filter: config registers, delay line,
// shared multiply-accumulate, saturation and output word. Depends on iirdf2_pkg.
module iirdf2_datapath
    import iirdf2_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic [IDX_WIDTH-1:0]      cfg_index,
    input  logic [REG_WIDTH-1:0]      cfg_data,
    input  logic [SAMPLE_WIDTH-1:0]   sample_in,
    input  iirdf2_cmd_t               cmd,
    output iirdf2_status_t            status,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_BYTES*8-1:0]    m_tdata,
    output logic [1:0]                m_tuser
);

    logic [CNT_WIDTH-1:0]          fb_count_reg, ff_count_reg;
    logic [2*REG_WIDTH-1:0]        fb_coefs_reg, ff_coefs_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [ACC_WIDTH-1:0]   acc_reg, acc_next;
    logic signed [STATE_WIDTH-1:0] w_reg;
    logic                          sat_reg;
    logic signed [STATE_WIDTH-1:0] dl_reg [MAX_ORDER];
    logic                          out_valid_reg;
    logic signed [STATE_WIDTH-1:0] out_y_reg;
    logic                          out_sat_reg, out_err_reg;

    logic signed [COEF_WIDTH-1:0]             coef;
    logic signed [STATE_WIDTH-1:0]            mac_data;
    logic signed [COEF_WIDTH+STATE_WIDTH-1:0] prod;
    logic signed [ACC_WIDTH-1:0]              acc_base;
    logic signed [SUM_WIDTH-1:0]              acc_shift;
    logic signed [SUM_WIDTH-1:0]              w_sum;
    logic signed [STATE_WIDTH-1:0]            w_sat, y_sat, y_val;
    logic                                     w_clip, y_clip;

    // hold clamped counts for the sequencer
    assign status.nf  = (fb_count_reg > CNT_WIDTH'(MAX_ORDER)) ?
                        CNT_WIDTH'(MAX_ORDER) : fb_count_reg;
    assign status.nff = (ff_count_reg > CNT_WIDTH'(MAX_ORDER)) ?
                        CNT_WIDTH'(MAX_ORDER) : ff_count_reg;
    assign status.out_busy = out_valid_reg && !m_tready;

    always_comb
    begin
        coef = cmd.coef_ff ? ff_coefs_reg[cmd.coef_idx*COEF_WIDTH +: COEF_WIDTH]
                           : fb_coefs_reg[cmd.coef_idx*COEF_WIDTH +: COEF_WIDTH];
        mac_data  = cmd.use_w ? w_reg : dl_reg[cmd.data_idx];
        prod      = coef * mac_data;
        acc_base  = cmd.acc_clear ? '0 : acc_reg;
        acc_next  = cmd.mac ? acc_base + ACC_WIDTH'(prod) : acc_base;
        acc_shift = SUM_WIDTH'(acc_reg >>> FRAC_BITS);
        w_sum     = SUM_WIDTH'(x_reg) + acc_shift;
    end

    // clip to the state width
    always_comb
    begin
        w_clip = 1'b0;
        w_sat  = w_sum[STATE_WIDTH-1:0];
        if (!w_sum[SUM_WIDTH-1] && (w_sum[SUM_WIDTH-2:STATE_WIDTH-1] != '0))
        begin
            w_clip = 1'b1;
            w_sat  = {1'b0, {(STATE_WIDTH-1){1'b1}}};
        end
        else if (w_sum[SUM_WIDTH-1] && (w_sum[SUM_WIDTH-2:STATE_WIDTH-1] != '1))
        begin
            w_clip = 1'b1;
            w_sat  = {1'b1, {(STATE_WIDTH-1){1'b0}}};
        end
        y_clip = 1'b0;
        y_sat  = acc_shift[STATE_WIDTH-1:0];
        if (!acc_shift[SUM_WIDTH-1] && (acc_shift[SUM_WIDTH-2:STATE_WIDTH-1] != '0))
        begin
            y_clip = 1'b1;
            y_sat  = {1'b0, {(STATE_WIDTH-1){1'b1}}};
        end
        else if (acc_shift[SUM_WIDTH-1] && (acc_shift[SUM_WIDTH-2:STATE_WIDTH-1] != '1))
        begin
            y_clip = 1'b1;
            y_sat  = {1'b1, {(STATE_WIDTH-1){1'b0}}};
        end
        y_val = cmd.y_bypass ? w_reg : y_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_count_reg <= '0;
            ff_count_reg <= '0;
            fb_coefs_reg <= '0;
            ff_coefs_reg <= '0;
            for (int i = 0; i < MAX_ORDER; i++)
                dl_reg[i] <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_FB_COUNT: fb_count_reg <= cfg_data[CNT_WIDTH-1:0];
                    REG_FF_COUNT: ff_count_reg <= cfg_data[CNT_WIDTH-1:0];
                    REG_FB_LOW:   fb_coefs_reg[REG_WIDTH-1:0] <= cfg_data;
                    REG_FB_HIGH:  fb_coefs_reg[2*REG_WIDTH-1:REG_WIDTH] <= cfg_data;
                    REG_FF_LOW:   ff_coefs_reg[REG_WIDTH-1:0] <= cfg_data;
                    REG_FF_HIGH:  ff_coefs_reg[2*REG_WIDTH-1:REG_WIDTH] <= cfg_data;
                    default: ;
                endcase
            end
            // advance the delay line with the new w
            if (cmd.finish && !cmd.err)
            begin
                for (int i = MAX_ORDER - 1; i > 0; i--)
                    dl_reg[i] <= dl_reg[i-1];
                dl_reg[0] <= w_reg;
            end
            out_valid_reg <= cmd.finish || (out_valid_reg && !m_tready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            x_reg <= sample_in;
        acc_reg <= acc_next;
        if (cmd.start)
            sat_reg <= 1'b0;
        else if (cmd.load_w)
            sat_reg <= w_clip;
        if (cmd.load_w)
            w_reg <= w_sat;
        if (cmd.finish)
        begin
            if (cmd.err)
            begin
                out_y_reg   <= '0;
                out_sat_reg <= 1'b0;
                out_err_reg <= 1'b1;
            end
            else
            begin
                out_y_reg   <= y_val;
                out_sat_reg <= sat_reg || (!cmd.y_bypass && y_clip);
                out_err_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = (OUT_BYTES*8)'(unsigned'(out_y_reg));
    assign m_tuser  = {out_err_reg, out_sat_reg};

    a_err_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> out_y_reg == '0 && !out_sat_reg)
        else $error("config error word carries data or a clip flag");

endmodule

@@ hdl/iir_filter_direct_form_two_top.sv @@
// Top level of the direct form II IIR filter with a shared delay line.
// Depends on iirdf2_pkg; instantiates iirdf2_ctrl and iirdf2_datapath.
//
// Filter y from x in Q2.14 fixed point with one shared multiply-accumulate
// unit. Each input word yields one output word. The feedback pass forms
// w = sat24(x + (sum a[k]*w[n-1-k]) >>> 14) over NF taps, the feedforward
// pass forms y = sat24((b[0]*w + sum b[k]*w[n-k]) >>> 14) over NF2 taps,
// then w enters the delay line. With NF2 = 0 the output is w itself; with
// both counts zero the output word is zero with config_error set and the
// delay line holds. Counts above 8 act as 8. Each word runs the feedback
// taps, the w step, the feedforward taps and a final step before the next
// is taken (a config error goes straight to the final step); the single
// MAC steps one tap per cycle. The output register parts the two sides,
// so a new word is accepted while the last result waits to be taken; the
// sequencer only stalls in its final step when that register is full. Write
// configuration only while the block is idle; cfg_ready is always high and
// writes to unknown indexes are dropped.
module iir_filter_direct_form_two_top
    import iirdf2_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_BYTES*8-1:0]  s_tdata,   // [15:0] sample_in
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_BYTES*8-1:0] m_tdata,   // [23:0] sample_out
    output logic [1:0]             m_tuser,   // [0] saturated, [1] config_error
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [IDX_WIDTH-1:0]   cfg_index,
    input  logic [REG_WIDTH-1:0]   cfg_data
);

    iirdf2_cmd_t    cmd;
    iirdf2_status_t status;

    assign cfg_ready = 1'b1;

    iirdf2_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    iirdf2_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_in (s_tdata[SAMPLE_WIDTH-1:0]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
